>>> rtl/exlex_pkg.sv
package exlex_pkg;

  // position counter width and saturation value
  localparam int unsigned POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // results one input request can produce
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W = $clog2(MAX_RES + 1);

  // token kinds
  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_NAME     = 3'd2;
  localparam logic [2:0] KIND_LBRACKET = 3'd3;
  localparam logic [2:0] KIND_RBRACKET = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_DOTS     = 2'd2;
  localparam logic [1:0] ERR_NAME_END = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // scanner mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_NAME   = 4'b0100,
    MODE_HALTED = 4'b1000
  } mode_t;

  // one token descriptor
  typedef struct packed {
    logic [2:0]       kind;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [7:0]       sym;
    logic [1:0]       err;
    logic             last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_CARET) || (c == CH_PCT);
  endfunction

  // saturating increment
  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] a);
    return (a == POS_MAX) ? a : a + 1'b1;
  endfunction

  // saturating sum
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

endpackage

>>> rtl/expression_lexer.sv
// Expression lexer: one character per request in, token descriptors out.
// An accepted input is held in the input register, then the scan logic
// loads its results into the result buffer. Throughput: one input per
// cycle while out_stall is low and each input yields at most one result;
// more results stall the input side until the last one is taken.
// Reset (rst_n low, synchronous) empties both registers and clears scan state.
module expression_lexer import exlex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_char_valid,
  input  logic       in_end_of_expression,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0]       out_token_kind,
  output logic [POS_W-1:0] out_token_position,
  output logic [POS_W-1:0] out_token_length,
  output logic [7:0]       out_symbol_char,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_run
);

  // input register
  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       chv_r;
  logic       eoe_r;

  // scan state
  mode_t            mode_r, mode_nxt;
  logic             seen_r, seen_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] rlen_r, rlen_nxt;
  logic [1:0]       dots_r, dots_nxt;
  logic             pend_r, pend_nxt;

  // result buffer, entry 0 is presented
  token_t           res_r [MAX_RES];
  token_t           res_nxt [MAX_RES];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_nxt;

  logic take;
  logic process;
  logic accept;
  logic done;

  assign take    = (cnt_r != '0) && !out_stall;
  assign process = in_vld_r && ((cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall));
  assign in_stall = in_vld_r && !process;
  assign accept  = in_valid && !in_stall;

  assign out_valid          = (cnt_r != '0);
  assign out_token_kind     = res_r[0].kind;
  assign out_token_position = res_r[0].pos;
  assign out_token_length   = res_r[0].len;
  assign out_symbol_char    = res_r[0].sym;
  assign out_error_code     = res_r[0].err;
  assign out_last_of_run    = res_r[0].last;

  // scan one character and build its results
  always_comb begin
    mode_nxt  = mode_r;
    seen_nxt  = seen_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    rlen_nxt  = rlen_r;
    dots_nxt  = dots_r;
    pend_nxt  = pend_r;
    n_nxt     = '0;
    done      = 1'b0;
    for (int i = 0; i < MAX_RES; i++) res_nxt[i] = '0;

    if (chv_r && (mode_r != MODE_HALTED)) begin
      // continue or close a running token
      if (mode_r == MODE_NUMBER) begin
        if (is_digit(ch_r) || (ch_r == CH_DOT)) begin
          if ((ch_r == CH_DOT) && (dots_r != 2'd2)) dots_nxt = dots_r + 2'd1;
          rlen_nxt = sat_inc(rlen_r);
          idx_nxt  = sat_inc(idx_r);
          done     = 1'b1;
        end else if (dots_r == 2'd2) begin
          res_nxt[n_nxt] = '{KIND_ERROR, sat_add(start_r, rlen_r), '0, 8'h00,
                             ERR_DOTS, 1'b0};
          n_nxt    = n_nxt + 1'b1;
          mode_nxt = MODE_HALTED;
          done     = 1'b1;
        end else begin
          res_nxt[n_nxt] = '{KIND_NUMBER, start_r, rlen_r, 8'h00, ERR_NONE, 1'b0};
          n_nxt    = n_nxt + 1'b1;
          mode_nxt = MODE_IDLE;
        end
      end else if (mode_r == MODE_NAME) begin
        if (is_alpha(ch_r) || is_digit(ch_r)) begin
          rlen_nxt = sat_inc(rlen_r);
          idx_nxt  = sat_inc(idx_r);
          done     = 1'b1;
        end else begin
          mode_nxt = MODE_IDLE;
          if (is_space(ch_r)) begin
            // name ended by whitespace: held until the next token shows up
            pend_nxt = 1'b1;
            idx_nxt  = sat_inc(idx_r);
            done     = 1'b1;
          end else begin
            res_nxt[n_nxt] = '{KIND_NAME, start_r, rlen_r, 8'h00, ERR_NONE, 1'b0};
            n_nxt = n_nxt + 1'b1;
          end
        end
      end

      // start a new token
      if (!done) begin
        if (is_space(ch_r)) begin
          if (seen_r) idx_nxt = sat_inc(idx_r);
        end else begin
          seen_nxt = 1'b1;
          if (pend_r) begin
            res_nxt[n_nxt] = '{KIND_NAME, start_r, rlen_r, 8'h00, ERR_NONE, 1'b0};
            n_nxt    = n_nxt + 1'b1;
            pend_nxt = 1'b0;
          end
          idx_nxt = sat_inc(idx_r);
          if (is_digit(ch_r)) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = idx_r;
            rlen_nxt  = POS_W'(1);
            dots_nxt  = 2'd0;
          end else if (is_alpha(ch_r)) begin
            mode_nxt  = MODE_NAME;
            start_nxt = idx_r;
            rlen_nxt  = POS_W'(1);
          end else if (is_op(ch_r)) begin
            res_nxt[n_nxt] = '{KIND_OPERATOR, idx_r, POS_W'(1), ch_r, ERR_NONE, 1'b0};
            n_nxt = n_nxt + 1'b1;
          end else if (ch_r == CH_LPAREN) begin
            res_nxt[n_nxt] = '{KIND_LBRACKET, idx_r, POS_W'(1), ch_r, ERR_NONE, 1'b0};
            n_nxt = n_nxt + 1'b1;
          end else if (ch_r == CH_RPAREN) begin
            res_nxt[n_nxt] = '{KIND_RBRACKET, idx_r, POS_W'(1), ch_r, ERR_NONE, 1'b0};
            n_nxt = n_nxt + 1'b1;
          end else begin
            res_nxt[n_nxt] = '{KIND_ERROR, idx_r, '0, 8'h00, ERR_UNKNOWN, 1'b0};
            n_nxt    = n_nxt + 1'b1;
            mode_nxt = MODE_HALTED;
            idx_nxt  = idx_r;
          end
        end
      end
    end

    // close the expression
    if (eoe_r) begin
      if (mode_nxt == MODE_NUMBER) begin
        if (dots_nxt == 2'd2) begin
          res_nxt[n_nxt] = '{KIND_ERROR, sat_add(start_nxt, rlen_nxt), '0, 8'h00,
                             ERR_DOTS, 1'b0};
        end else begin
          res_nxt[n_nxt] = '{KIND_NUMBER, start_nxt, rlen_nxt, 8'h00, ERR_NONE, 1'b0};
        end
        n_nxt = n_nxt + 1'b1;
      end else if ((mode_nxt == MODE_NAME) || ((mode_nxt != MODE_HALTED) && pend_nxt)) begin
        res_nxt[n_nxt] = '{KIND_ERROR, sat_add(start_nxt, rlen_nxt), '0, 8'h00,
                           ERR_NAME_END, 1'b0};
        n_nxt = n_nxt + 1'b1;
      end
      res_nxt[n_nxt] = '{KIND_END, '0, '0, 8'h00, ERR_NONE, 1'b0};
      n_nxt     = n_nxt + 1'b1;
      mode_nxt  = MODE_IDLE;
      seen_nxt  = 1'b0;
      idx_nxt   = '0;
      start_nxt = '0;
      rlen_nxt  = '0;
      dots_nxt  = 2'd0;
      pend_nxt  = 1'b0;
    end

    // flag the final result of this request
    if (n_nxt != '0) res_nxt[n_nxt - 1'b1].last = 1'b1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (process) begin
      in_vld_r <= 1'b0;
    end
    if (accept) begin
      ch_r  <= in_char_code;
      chv_r <= in_char_valid;
      eoe_r <= in_end_of_expression;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      seen_r  <= 1'b0;
      idx_r   <= '0;
      start_r <= '0;
      rlen_r  <= '0;
      dots_r  <= 2'd0;
      pend_r  <= 1'b0;
    end else if (process) begin
      mode_r  <= mode_nxt;
      seen_r  <= seen_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      rlen_r  <= rlen_nxt;
      dots_r  <= dots_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // result buffer: load on process, shift down as results are taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (process) begin
      cnt_r <= n_nxt;
    end else if (take) begin
      cnt_r <= cnt_r - 1'b1;
    end
    if (process) begin
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= res_nxt[i];
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) res_r[i] <= res_r[i+1];
    end
  end

endmodule
